/* rtl/core/fcr_pkg.sv */
// Shared types, constants and the CRC-8 fold function of the framed command receiver.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package fcr_pkg;

  // Width of the frame length and of the payload byte counter.
  localparam int CNT_W = 7;

  // Depth of the frame descriptor queue, which is also the number of payload banks.
  localparam logic [1:0] QUEUE_DEPTH = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SYNC_BYTE    = 2'd0;
  localparam logic [1:0] CFG_CRC_POLY     = 2'd1;
  localparam logic [1:0] CFG_CRC_SEED     = 2'd2;
  localparam logic [1:0] CFG_LENGTH_LIMIT = 2'd3;

  // Configuration reset values.
  localparam logic [7:0]       SYNC_RESET  = 8'hAA;
  localparam logic [7:0]       POLY_RESET  = 8'h31;
  localparam logic [7:0]       SEED_RESET  = 8'h00;
  localparam logic [CNT_W-1:0] LIMIT_RESET = 7'd64;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_TYPE   = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_LEN_HI = 3'd3,
    PH_DATA   = 3'd4,
    PH_CHECK  = 3'd5
  } phase_t;

  // Configuration as seen by the parser.
  typedef struct packed {
    logic [7:0]       sync_byte;
    logic [7:0]       crc_poly;
    logic [7:0]       crc_seed;
    logic [CNT_W-1:0] length_limit;
  } cfg_t;

  // One accepted frame waiting to be emitted.
  typedef struct packed {
    logic [7:0]       frame_type;
    logic [CNT_W-1:0] frame_length;
  } desc_t;

  // Payload store write port.
  typedef struct packed {
    logic             en;
    logic             bank;
    logic [CNT_W-1:0] addr;
    logic [7:0]       data;
  } mem_wr_t;

  // Fold one byte into an MSB-first CRC-8.
  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/core/fcr_front.sv */
// Frame parser: hunts for sync, checks the length, keeps the CRC and writes the payload.
// Depends on fcr_pkg; feeds the descriptor queue and the payload store in fcr_back.
`timescale 1ns / 1ps

module fcr_front
  import fcr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  input  logic [1:0] q_count,
  output logic       desc_push,
  output desc_t      desc,
  output mem_wr_t    mem_wr
);

  phase_t           phase_r, phase_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [7:0]       len_lo_r, len_lo_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic             bank_r, bank_nxt;

  logic             accept;
  logic [7:0]       crc_base;
  logic [7:0]       crc_new;
  logic [15:0]      len16;
  logic             too_long;
  logic [CNT_W-1:0] cnt_inc;
  logic             crc_match;

  // Both banks are held by frames still being emitted.
  assign full   = ((phase_r == PH_DATA) || (phase_r == PH_CHECK)) && (q_count == QUEUE_DEPTH);
  assign accept = push && !full;

  // The type byte restarts the CRC from the seed; later bytes continue it.
  assign crc_base  = (phase_r == PH_TYPE) ? cfg.crc_seed : crc_r;
  assign crc_new   = crc8_fold(crc_base, rx_byte, cfg.crc_poly);
  assign len16     = {rx_byte, len_lo_r};
  assign too_long  = (len16 > 16'(MAX_PAYLOAD)) || (len16 > {9'd0, cfg.length_limit});
  assign cnt_inc   = cnt_r + 7'd1;
  assign crc_match = (rx_byte == crc_r);

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      unique case (phase_r)
        PH_TYPE:   phase_nxt = PH_LEN_LO;
        PH_LEN_LO: phase_nxt = PH_LEN_HI;
        PH_LEN_HI: begin
          if (too_long) begin
            phase_nxt = PH_HUNT;
          end else if (len16 == 16'd0) begin
            phase_nxt = PH_CHECK;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA:   phase_nxt = (cnt_inc >= len_r) ? PH_CHECK : PH_DATA;
        PH_CHECK:  phase_nxt = PH_HUNT;
        default:   phase_nxt = (rx_byte == cfg.sync_byte) ? PH_TYPE : PH_HUNT;
      endcase
    end
  end

  // Datapath updates, payload writes and descriptor pushes.
  always_comb begin
    type_nxt   = type_r;
    len_lo_nxt = len_lo_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    crc_nxt    = crc_r;
    bank_nxt   = bank_r;
    desc_push  = 1'b0;
    mem_wr.en   = 1'b0;
    mem_wr.bank = bank_r;
    mem_wr.addr = cnt_r;
    mem_wr.data = rx_byte;
    if (accept) begin
      unique case (phase_r)
        PH_TYPE: begin
          type_nxt = rx_byte;
          crc_nxt  = crc_new;
        end
        PH_LEN_LO: begin
          len_lo_nxt = rx_byte;
          crc_nxt    = crc_new;
        end
        PH_LEN_HI: begin
          crc_nxt = crc_new;
          if (!too_long) begin
            len_nxt = len16[CNT_W-1:0];
            cnt_nxt = '0;
          end
        end
        PH_DATA: begin
          mem_wr.en = ({1'b0, cnt_r} < 8'(MAX_PAYLOAD));
          cnt_nxt   = cnt_inc;
          crc_nxt   = crc_new;
        end
        PH_CHECK: begin
          if (crc_match) begin
            desc_push = 1'b1;
            bank_nxt  = !bank_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign desc.frame_type   = type_r;
  assign desc.frame_length = len_r;

  // Parser registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      type_r   <= '0;
      len_lo_r <= '0;
      len_r    <= '0;
      cnt_r    <= '0;
      crc_r    <= '0;
      bank_r   <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      type_r   <= type_nxt;
      len_lo_r <= len_lo_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      crc_r    <= crc_nxt;
      bank_r   <= bank_nxt;
    end
  end

endmodule

/* rtl/core/fcr_desc_queue.sv */
// Two-entry queue of accepted frame descriptors between the parser and the emitter.
// Depends on fcr_pkg.
`timescale 1ns / 1ps

module fcr_desc_queue
  import fcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  desc_t      wr_desc,
  input  logic       rd_en,
  output desc_t      head,
  output logic       head_valid,
  output logic [1:0] count
);

  desc_t      entry_r [2];
  logic       wp_r, rp_r;
  logic [1:0] count_r, count_nxt;

  assign head       = entry_r[rp_r];
  assign head_valid = (count_r != 2'd0);
  assign count      = count_r;

  // Occupancy follows pushes and pops.
  always_comb begin
    count_nxt = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 2'd1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r[wp_r] <= wr_desc;
    end
  end

  // Pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= 1'b0;
      rp_r    <= 1'b0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (wr_en) begin
        wp_r <= !wp_r;
      end
      if (rd_en) begin
        rp_r <= !rp_r;
      end
    end
  end

endmodule

/* rtl/core/fcr_back.sv */
// Frame emitter: holds the two-bank payload store and streams each queued frame out.
// Depends on fcr_pkg; takes writes from fcr_front and descriptors from fcr_desc_queue.
`timescale 1ns / 1ps

module fcr_back
  import fcr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  mem_wr_t          mem_wr,
  input  desc_t            head,
  input  logic             head_valid,
  output logic             head_pop,
  output logic             empty,
  input  logic             pop,
  output logic [7:0]       out_frame_type,
  output logic [CNT_W-1:0] out_frame_length,
  output logic [7:0]       out_data_byte,
  output logic             out_has_data,
  output logic             out_last
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [7:0] mem [2][MAX_PAYLOAD];
  logic [7:0] rdata_r;

  logic [CNT_W-1:0] k_r, k_nxt;
  logic             bank_r;

  // Read stage: the payload byte read from the store is registered in rdata_r.
  logic             s1_valid_r, s1_valid_nxt;
  logic [7:0]       s1_type_r;
  logic [CNT_W-1:0] s1_len_r;
  logic             s1_has_r;
  logic             s1_last_r;

  // Output register.
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       o_type_r;
  logic [CNT_W-1:0] o_len_r;
  logic [7:0]       o_data_r;
  logic             o_has_r;
  logic             o_last_r;

  logic             out_take;
  logic             out_free;
  logic             s1_move;
  logic             issue;
  logic             head_has;
  logic [CNT_W-1:0] n_res;
  logic             last_k;

  assign out_take = pop && out_valid_r;
  assign out_free = !out_valid_r || out_take;
  assign s1_move  = s1_valid_r && out_free;
  assign issue    = head_valid && (!s1_valid_r || out_free);

  // An empty frame still gives one result.
  assign head_has = (head.frame_length != '0);
  assign n_res    = head_has ? head.frame_length : 7'd1;
  assign last_k   = ((k_r + 7'd1) == n_res);
  assign head_pop = issue && last_k;

  // Walk the payload of the head frame.
  always_comb begin
    k_nxt = k_r;
    if (issue) begin
      k_nxt = last_k ? '0 : (k_r + 7'd1);
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (issue) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Payload store: written by the parser, read by the emitter from the other bank.
  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      mem[mem_wr.bank][mem_wr.addr[AW-1:0]] <= mem_wr.data;
    end
    if (issue && head_has) begin
      rdata_r <= mem[bank_r][k_r[AW-1:0]];
    end
  end

  // Payload registers of the read stage and the output stage.
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_type_r <= head.frame_type;
      s1_len_r  <= head.frame_length;
      s1_has_r  <= head_has;
      s1_last_r <= last_k;
    end
    if (s1_move) begin
      o_type_r <= s1_type_r;
      o_len_r  <= s1_len_r;
      o_data_r <= s1_has_r ? rdata_r : 8'd0;
      o_has_r  <= s1_has_r;
      o_last_r <= s1_last_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      bank_r      <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      k_r         <= k_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (head_pop) begin
        bank_r <= !bank_r;
      end
    end
  end

  assign empty            = !out_valid_r;
  assign out_frame_type   = o_type_r;
  assign out_frame_length = o_len_r;
  assign out_data_byte    = o_data_r;
  assign out_has_data     = o_has_r;
  assign out_last         = o_last_r;

endmodule

/* rtl/core/framed_command_receiver_crc8.sv */
// Top level of the framed command receiver: configuration registers and the three parts.
// Depends on fcr_pkg, fcr_front, fcr_desc_queue and fcr_back.
//
// Usage:
// The input side is a queue: drive one received byte on in_rx_byte and raise push; the
// item is taken at a clock edge where push is high and full is low. Bytes before a sync
// byte are dropped. A frame is sync, type, length low, length high, payload, CRC.
// The result side is a queue too: while empty is low the oldest result is on the out_
// ports, and it is taken at an edge where pop is high. A frame whose CRC matches gives
// one result per payload byte with out_last on the final one; an empty frame gives one
// result with out_has_data low. Frames that are too long or fail the CRC give nothing.
// A frame whose CRC byte is taken has its descriptor queued; its first result then passes
// the read stage and the output register. One byte per cycle goes in while full is low,
// one result per cycle comes out while pop is high. The payload store has two banks, so
// one frame can be received while the previous one is emitted; full rises only in the
// payload or CRC phase of a frame while two earlier frames still wait to be emitted, and
// falls the cycle after the emitter has read the last payload byte of the older one.
// Reset (rst_n low at a clock edge) returns the parser to sync hunting, empties the
// queues and loads the configuration defaults; the payload store is not cleared.
// A stalled receiver (pop low) holds the current result; input continues until the
// banks fill. Configuration is written through cfg_wr_en, cfg_index and cfg_data.
`timescale 1ns / 1ps

module framed_command_receiver_crc8
  import fcr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       in_rx_byte,
  output logic             empty,
  input  logic             pop,
  output logic [7:0]       out_frame_type,
  output logic [CNT_W-1:0] out_frame_length,
  output logic [7:0]       out_data_byte,
  output logic             out_has_data,
  output logic             out_last,
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_index,
  input  logic [7:0]       cfg_data
);

  cfg_t       cfg_r;
  desc_t      desc;
  desc_t      head;
  mem_wr_t    mem_wr;
  logic       desc_push;
  logic       head_valid;
  logic       head_pop;
  logic [1:0] q_count;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_byte    <= SYNC_RESET;
      cfg_r.crc_poly     <= POLY_RESET;
      cfg_r.crc_seed     <= SEED_RESET;
      cfg_r.length_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SYNC_BYTE:    cfg_r.sync_byte    <= cfg_data;
        CFG_CRC_POLY:     cfg_r.crc_poly     <= cfg_data;
        CFG_CRC_SEED:     cfg_r.crc_seed     <= cfg_data;
        CFG_LENGTH_LIMIT: cfg_r.length_limit <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fcr_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .push     (push),
    .full     (full),
    .rx_byte  (in_rx_byte),
    .q_count  (q_count),
    .desc_push(desc_push),
    .desc     (desc),
    .mem_wr   (mem_wr)
  );

  fcr_desc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (desc_push),
    .wr_desc   (desc),
    .rd_en     (head_pop),
    .head      (head),
    .head_valid(head_valid),
    .count     (q_count)
  );

  fcr_back #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .mem_wr          (mem_wr),
    .head            (head),
    .head_valid      (head_valid),
    .head_pop        (head_pop),
    .empty           (empty),
    .pop             (pop),
    .out_frame_type  (out_frame_type),
    .out_frame_length(out_frame_length),
    .out_data_byte   (out_data_byte),
    .out_has_data    (out_has_data),
    .out_last        (out_last)
  );

endmodule

/* rtl/core/fcr_checker.sv */
// Port-level checks for the framed command receiver, bound to its top level.
// Depends on fcr_pkg and framed_command_receiver_crc8.
`timescale 1ns / 1ps

module fcr_checker
  import fcr_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             full,
  input logic             empty,
  input logic             pop,
  input logic [7:0]       out_frame_type,
  input logic [CNT_W-1:0] out_frame_length,
  input logic [7:0]       out_data_byte,
  input logic             out_has_data,
  input logic             out_last
);

  // Reset leaves no result waiting and the input open.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> (empty && !full))
    else $error("results or stall present after reset");

  // A result that is not taken stays as it is.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_frame_type) && $stable(out_frame_length)
                          && $stable(out_data_byte) && $stable(out_has_data)
                          && $stable(out_last)))
    else $error("waiting result changed");

  // Only a frame with no payload gives a result without data.
  a_len_data: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> ((out_frame_length == '0) == !out_has_data))
    else $error("frame length and data flag disagree");

  // A result without data is the single, final result of its frame and carries zero.
  a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_has_data) |-> (out_last && (out_data_byte == 8'd0)))
    else $error("empty frame result malformed");

  // No frame is longer than the store.
  a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_frame_length <= 7'd64))
    else $error("frame length beyond the payload store");

endmodule

bind framed_command_receiver_crc8 fcr_checker u_fcr_checker (.*);
